FILE: rtl/ert_pkg.sv
// Shared types and constants for the epoch reclamation tracker.
package ert_pkg;
    localparam int THREADS    = 16;
    localparam int BAG_DEPTH  = 16;
    localparam int PAGE_BITS  = 16;
    localparam int EPOCH_BITS = 32;
    localparam int NBAGS      = 3;
    localparam int TID_W      = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int CNT_W      = $clog2(BAG_DEPTH + 1);
    localparam int SLOT_W     = (BAG_DEPTH > 1) ? $clog2(BAG_DEPTH) : 1;
    localparam int MEM_DEPTH  = NBAGS * BAG_DEPTH;
    localparam int MADDR_W    = $clog2(MEM_DEPTH);

    typedef logic [1:0]            func_t;
    typedef logic [1:0]            bag_idx_t;
    typedef logic [EPOCH_BITS-1:0] epoch_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    localparam func_t FUNC_PIN     = 2'd0;
    localparam func_t FUNC_UNPIN   = 2'd1;
    localparam func_t FUNC_RETIRE  = 2'd2;
    localparam func_t FUNC_QUIESCE = 2'd3;

    localparam epoch_t EPOCH_MAX = {EPOCH_BITS{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EVAL,
        ST_DRAIN_RD,
        ST_DRAIN_OUT,
        ST_PUSH,
        ST_RESP
    } state_t;

    // Datapath commands from controller.
    typedef struct packed {
        logic     latch_in;
        logic     apply_pinop;
        logic     scan_clear;
        logic     scan_step;
        logic     advance;
        logic     set_bag;
        bag_idx_t bag;
        logic     drain_rd;
        logic     push;
        logic     set_reject;
        logic     emit_page;
        logic     emit_last;
        logic     out_ready;
    } ctrl_cmd_t;

    // Datapath status back to controller.
    typedef struct packed {
        func_t    func;
        logic     scan_done;
        logic     bag_nonempty;
        logic     bag_safe;
        logic     bag_tag_eq;
        logic     bag_full;
        logic     more_bags;
        bag_idx_t cur_bag;
        logic     out_busy;
        logic     emitted_any;
    } ctrl_sts_t;
endpackage

FILE: rtl/ert_datapath.sv
// Datapath: epoch, thread table, bags, page memory and output register.
module ert_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ert_pkg::ctrl_cmd_t     cmd,
    output ert_pkg::ctrl_sts_t     sts,
    input  logic [1:0]             s_func,
    input  logic [3:0]             s_thread_id,
    input  logic [15:0]            s_page_id,
    output logic                   m_valid,
    output logic                   m_page_valid,
    output logic [15:0]            m_reclaimed_page,
    output logic                   m_last,
    output logic [31:0]            m_current_epoch,
    output logic                   m_status
);
    import ert_pkg::*;

    epoch_t                 epoch_reg;
    bag_idx_t               emod_reg;
    logic [THREADS-1:0]     pinned_reg;
    epoch_t                 tepoch_reg [THREADS];
    cnt_t                   count_reg [NBAGS];
    epoch_t                 tag_reg [NBAGS];
    logic [PAGE_BITS-1:0]   mem [MEM_DEPTH];
    logic [PAGE_BITS-1:0]   rd_reg;

    func_t                  func_reg;
    logic [3:0]             tid_reg;
    logic [PAGE_BITS-1:0]   page_reg;
    logic                   reject_reg;
    logic                   any_reg;
    bag_idx_t               bag_reg;

    // scan state
    logic [TID_W:0]         sidx_reg;
    logic                   lag_reg;
    logic [NBAGS-1:0]       block_reg;

    logic                   ov_reg;
    logic                   opv_reg;
    logic [15:0]            opage_reg;
    logic                   olast_reg;
    logic                   ostat_reg;

    logic                   tid_ok;
    logic [TID_W-1:0]       tid_i;
    logic [TID_W-1:0]       sidx_i;
    bag_idx_t               cur_bag;
    cnt_t                   ccnt;
    epoch_t                 ctag;
    logic [MADDR_W-1:0]     rd_addr;
    logic [MADDR_W-1:0]     wr_addr;
    logic [NBAGS-1:0]       ready_vec;

    assign tid_i   = tid_reg[TID_W-1:0];
    assign tid_ok  = ({4'd0, tid_reg} < 8'(THREADS));
    assign sidx_i  = sidx_reg[TID_W-1:0];
    assign cur_bag = emod_reg;
    assign ccnt    = count_reg[bag_reg];
    assign ctag    = tag_reg[bag_reg];
    assign rd_addr = MADDR_W'(bag_reg) * MADDR_W'(BAG_DEPTH) + MADDR_W'(ccnt - 1'b1);
    assign wr_addr = MADDR_W'(bag_reg) * MADDR_W'(BAG_DEPTH) + MADDR_W'(ccnt);

    // bags that a quiesce drain would empty
    always_comb begin
        for (int b = 0; b < NBAGS; b++)
            ready_vec[b] = (count_reg[b] != '0) && (tag_reg[b] <= epoch_reg)
                           && ((epoch_reg - tag_reg[b]) >= epoch_t'(2)) && !block_reg[b];
    end

    always_comb begin
        sts.func         = func_reg;
        sts.scan_done    = (sidx_reg == (TID_W+1)'(THREADS));
        sts.bag_nonempty = (ccnt != '0);
        sts.bag_tag_eq   = (ctag == epoch_reg);
        sts.bag_safe     = (ctag <= epoch_reg) && ((epoch_reg - ctag) >= epoch_t'(2))
                           && !block_reg[bag_reg];
        sts.bag_full     = (ccnt >= cnt_t'(BAG_DEPTH));
        sts.more_bags    = 1'b0;
        for (int b = 0; b < NBAGS; b++)
            if (bag_idx_t'(b) > bag_reg && ready_vec[b])
                sts.more_bags = 1'b1;
        sts.cur_bag      = cur_bag;
        sts.out_busy     = ov_reg;
        sts.emitted_any  = any_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push)
            mem[wr_addr] <= page_reg;
        if (cmd.drain_rd)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            func_reg <= s_func;
            tid_reg  <= s_thread_id;
            page_reg <= PAGE_BITS'(s_page_id);
        end
        if (cmd.apply_pinop && func_reg == FUNC_PIN && tid_ok)
            tepoch_reg[tid_i] <= epoch_reg;
        if (cmd.set_bag)
            bag_reg <= cmd.bag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg  <= '0;
            emod_reg   <= '0;
            pinned_reg <= '0;
            for (int b = 0; b < NBAGS; b++) begin
                count_reg[b] <= '0;
                tag_reg[b]   <= '0;
            end
            sidx_reg   <= '0;
            lag_reg    <= 1'b0;
            block_reg  <= '0;
            reject_reg <= 1'b0;
            any_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            if (cmd.latch_in) begin
                reject_reg <= 1'b0;
                any_reg    <= 1'b0;
            end
            if (cmd.apply_pinop && tid_ok && func_reg != FUNC_RETIRE)
                pinned_reg[tid_i] <= (func_reg == FUNC_PIN);
            if (cmd.scan_clear) begin
                sidx_reg  <= '0;
                lag_reg   <= 1'b0;
                block_reg <= '0;
            end else if (cmd.scan_step) begin
                if (pinned_reg[sidx_i]) begin
                    if (tepoch_reg[sidx_i] < epoch_reg)
                        lag_reg <= 1'b1;
                    for (int b = 0; b < NBAGS; b++)
                        if (tepoch_reg[sidx_i] <= tag_reg[b])
                            block_reg[b] <= 1'b1;
                end
                sidx_reg <= sidx_reg + 1'b1;
            end
            if (cmd.advance && !lag_reg && epoch_reg != EPOCH_MAX) begin
                epoch_reg <= epoch_reg + 1'b1;
                emod_reg  <= (emod_reg == bag_idx_t'(NBAGS - 1)) ? '0 : emod_reg + 1'b1;
            end
            if (cmd.drain_rd)
                count_reg[bag_reg] <= ccnt - 1'b1;
            if (cmd.push) begin
                count_reg[bag_reg] <= ccnt + 1'b1;
                tag_reg[bag_reg]   <= epoch_reg;
            end
            if (cmd.set_reject)
                reject_reg <= 1'b1;
            if (cmd.emit_page || cmd.emit_last) begin
                ov_reg    <= 1'b1;
                opv_reg   <= cmd.emit_page;
                opage_reg <= cmd.emit_page ? 16'(rd_reg) : 16'd0;
                olast_reg <= cmd.emit_last;
                ostat_reg <= reject_reg;
                if (cmd.emit_page)
                    any_reg <= 1'b1;
            end else if (cmd.out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = ov_reg;
    assign m_page_valid     = opv_reg;
    assign m_reclaimed_page = opage_reg;
    assign m_last           = olast_reg;
    assign m_current_epoch  = 32'(epoch_reg);
    assign m_status         = ostat_reg;
endmodule

FILE: rtl/ert_ctrl.sv
// Controller state machine sequencing pin ops, scans, drains and pushes.
module ert_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                m_ready,
    output ert_pkg::ctrl_cmd_t  cmd,
    input  ert_pkg::ctrl_sts_t  sts
);
    import ert_pkg::*;

    state_t   state_reg, state_next;
    bag_idx_t bi_reg, bi_next;
    logic     flush_reg, flush_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bi_reg    <= '0;
            flush_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            bi_reg    <= bi_next;
            flush_reg <= flush_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        bi_next       = bi_reg;
        flush_next    = flush_reg;
        cmd           = '0;
        cmd.out_ready = m_ready;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = !sts.out_busy;
                if (s_valid && !sts.out_busy) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.apply_pinop = 1'b1;
                cmd.scan_clear  = 1'b1;
                case (sts.func)
                    FUNC_PIN, FUNC_UNPIN: state_next = ST_RESP;
                    FUNC_RETIRE: begin
                        cmd.set_bag = 1'b1;
                        cmd.bag     = sts.cur_bag;
                        flush_next  = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    default: begin
                        flush_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                endcase
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    if (flush_reg) begin
                        state_next = ST_EVAL;
                    end else begin
                        // epoch advance (held if a pinned thread lags or the epoch is at max), then rescan
                        cmd.advance    = 1'b1;
                        cmd.scan_clear = 1'b1;
                        flush_next     = 1'b1;
                        bi_next        = 2'd0;
                        cmd.set_bag    = 1'b1;
                        cmd.bag        = 2'd0;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EVAL: begin
                if (sts.func == FUNC_RETIRE) begin
                    if (sts.bag_nonempty && !sts.bag_tag_eq && sts.bag_safe)
                        state_next = ST_DRAIN_RD;
                    else
                        state_next = ST_PUSH;
                end else if (sts.bag_nonempty && sts.bag_safe) begin
                    state_next = ST_DRAIN_RD;
                end else if (bi_reg == bag_idx_t'(NBAGS - 1)) begin
                    state_next = ST_RESP;
                end else begin
                    bi_next     = bi_reg + 1'b1;
                    cmd.set_bag = 1'b1;
                    cmd.bag     = bi_reg + 1'b1;
                end
            end
            ST_DRAIN_RD: begin
                if (!sts.out_busy || m_ready) begin
                    cmd.drain_rd = 1'b1;
                    state_next   = ST_DRAIN_OUT;
                end
            end
            ST_DRAIN_OUT: begin
                if (!sts.out_busy || m_ready) begin
                    cmd.emit_page = 1'b1;
                    // final page: bag now empty and, for a quiesce, no later bag will drain
                    cmd.emit_last = !sts.bag_nonempty &&
                                    (sts.func == FUNC_RETIRE || !sts.more_bags);
                    if (sts.bag_nonempty) begin
                        state_next = ST_DRAIN_RD;
                    end else if (sts.func == FUNC_RETIRE) begin
                        state_next = ST_PUSH;
                    end else if (bi_reg == bag_idx_t'(NBAGS - 1)) begin
                        state_next = ST_RESP;
                    end else begin
                        bi_next     = bi_reg + 1'b1;
                        cmd.set_bag = 1'b1;
                        cmd.bag     = bi_reg + 1'b1;
                        state_next  = ST_EVAL;
                    end
                end
            end
            ST_PUSH: begin
                if (sts.bag_full)
                    cmd.set_reject = 1'b1;
                else
                    cmd.push = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // marker-only beat when no page went out; the last page already carried last
                if (!sts.out_busy || m_ready) begin
                    if (!sts.emitted_any) begin
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/epoch_reclamation_tracker_unit.sv
// Top level of the epoch reclamation tracker.
//   channel | ports                                              | dir
//   input   | s_valid s_ready s_func s_thread_id s_page_id        | in
//   result  | m_valid m_ready m_page_valid m_reclaimed_page m_last | out
//           | m_current_epoch m_status                           |
// The first beat of a pin or unpin goes out straight after decode; a retire
// first runs one slot scan and checks its bag, a quiesce runs two slot scans
// around the epoch advance and then the bag checks; each reclaimed page is read and then sent out.
// The next beat is taken in the cycle after the final beat leaves.
// Reset is synchronous active low and clears epoch, pins, bag counts and tags.
// A stalled result holds the sequencer; the next item waits for the last beat.
module epoch_reclamation_tracker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [3:0]  s_thread_id,
    input  logic [15:0] s_page_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_page_valid,
    output logic [15:0] m_reclaimed_page,
    output logic        m_last,
    output logic [31:0] m_current_epoch,
    output logic        m_status
);
    import ert_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      lk_valid, lk_pv, lk_last, lk_stat;
    logic [15:0] lk_page;
    logic [31:0] lk_epoch;

    ert_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    ert_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_func(s_func), .s_thread_id(s_thread_id), .s_page_id(s_page_id),
        .m_valid(lk_valid), .m_page_valid(lk_pv), .m_reclaimed_page(lk_page),
        .m_last(lk_last), .m_current_epoch(lk_epoch), .m_status(lk_stat)
    );

    assign m_valid          = lk_valid;
    assign m_page_valid     = lk_pv;
    assign m_reclaimed_page = lk_page;
    assign m_last           = lk_last;
    assign m_current_epoch  = lk_epoch;
    assign m_status         = lk_stat;
endmodule
